// File: rtl/lsps_pkg.sv
// Shared types, constants and sequencing functions of the LED status pattern sequencer.
package lsps_pkg;

  // Number of pattern phases; nibbles of the 32-bit mask give their durations.
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_W      = $clog2(PHASE_COUNT);
  localparam int NIBBLE_COUNT = 32 / 4;

  // Configuration port.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic REG_UNIT_TICKS = 1'b0;
  localparam logic [15:0] UNIT_TICKS_RESET = 16'd1;

  // Opcodes.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_STATUS = 3'd1;
  localparam logic [2:0] OP_BLINK  = 3'd2;
  localparam logic [2:0] OP_STEADY = 3'd3;
  localparam logic [2:0] OP_ACCESS = 3'd4;

  // Status codes and their duration masks.
  localparam logic [2:0] ST_ERROR   = 3'd0;
  localparam logic [2:0] ST_AP      = 3'd1;
  localparam logic [2:0] ST_CONNECT = 3'd2;
  localparam logic [2:0] ST_IDLE    = 3'd3;
  localparam logic [2:0] ST_ACTIVE  = 3'd4;

  localparam logic [31:0] MASK_ERROR   = 32'h2323_2328;
  localparam logic [31:0] MASK_AP      = 32'h0000_111d;
  localparam logic [31:0] MASK_CONNECT = 32'h0000_001f;
  localparam logic [31:0] MASK_IDLE    = 32'h0000_00f1;
  localparam logic [31:0] MASK_ACTIVE  = 32'h0000_0088;
  localparam logic [31:0] MASK_ON      = 32'h0000_0000;
  localparam logic [31:0] MASK_OFF     = 32'hffff_ffff;

  // Wait durations in timing units, and the burst length of a failed access.
  localparam logic [4:0] FLASH_UNITS = 5'd4;
  localparam logic [4:0] BLINK_UNITS = 5'd1;
  localparam logic [7:0] FAIL_BLINKS = 8'd2;

  typedef enum logic [5:0] {
    MODE_STEADY    = 6'b000001,
    MODE_PATTERN   = 6'b000010,
    MODE_FLASH     = 6'b000100,
    MODE_BURST_ON  = 6'b001000,
    MODE_BURST_OFF = 6'b010000,
    MODE_TAIL      = 6'b100000
  } mode_t;

  // Points at which the sequencer resumes after a wait or a wake.
  typedef enum logic [2:0] {
    GO_TOP        = 3'd0,
    GO_FLASH_DONE = 3'd1,
    GO_ON_DONE    = 3'd2,
    GO_OFF_DONE   = 3'd3,
    GO_TAIL_DONE  = 3'd4
  } go_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] status_code;
    logic [7:0] blink_count;
    logic       flag;
  } cmd_t;

  typedef struct packed {
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
  } apb_req_t;

  typedef struct packed {
    logic [31:0]        mask;
    logic [7:0]         burst;
    logic               flash;
    logic               wake;
    logic [PHASE_W-1:0] phase;
    mode_t              mode;
    logic [4:0]         units;
    logic [15:0]        prescale;
    logic               red;
    logic               green;
  } seq_t;

  function automatic logic [31:0] status_mask(logic [2:0] code);
    logic [31:0] m;
    unique case (code)
      ST_ERROR:   m = MASK_ERROR;
      ST_AP:      m = MASK_AP;
      ST_CONNECT: m = MASK_CONNECT;
      ST_IDLE:    m = MASK_IDLE;
      ST_ACTIVE:  m = MASK_ACTIVE;
      default:    m = MASK_ON;
    endcase
    return m;
  endfunction

  // Phases past the last nibble of the mask read as zero.
  function automatic logic [3:0] nibble_at(logic [31:0] mask, logic [PHASE_W-1:0] ph);
    logic [31:0] sh;
    sh = mask >> {ph, 2'b00};
    if (32'(ph) >= 32'(NIBBLE_COUNT)) begin
      return 4'h0;
    end
    return sh[3:0];
  endfunction

  function automatic seq_t start_wait(seq_t s, mode_t m, logic [4:0] u);
    seq_t r;
    r = s;
    r.mode     = m;
    r.units    = u;
    r.prescale = '0;
    return r;
  endfunction

  // One pass through the pattern point. A pending wake is consumed here
  // instead of starting a wait; the caller then restarts from the top.
  function automatic seq_t pattern_step(seq_t s);
    seq_t               r;
    logic [PHASE_W-1:0] ph;
    logic [3:0]         d;
    r  = s;
    ph = '0;
    d  = '0;
    if (s.mask == MASK_ON || s.mask == MASK_OFF) begin
      r.red = (s.mask != MASK_ON);
      if (s.wake) begin
        r.wake = 1'b0;
      end else begin
        r.mode  = MODE_STEADY;
        r.units = '0;
      end
    end else begin
      if (32'(s.phase) + 32'd1 >= 32'(PHASE_COUNT)) begin
        ph = '0;
      end else begin
        ph = s.phase + PHASE_W'(1);
      end
      d = nibble_at(s.mask, ph);
      if (d == 4'h0) begin
        ph = '0;
        d  = nibble_at(s.mask, ph);
        if (d == 4'h0) begin
          d = 4'h1;
        end
      end
      r.phase = ph;
      r.red   = ph[0];
      if (s.wake) begin
        r.wake = 1'b0;
      end else begin
        r = start_wait(r, MODE_PATTERN, {d, 1'b0});
      end
    end
    return r;
  endfunction

  // Runs the sequencer from a resume point until it enters a wait. The pattern
  // point is reached at most twice: once with a pending wake, once without.
  function automatic seq_t seq_run(seq_t s, go_t at);
    seq_t r;
    logic to_burst;
    logic to_pattern;
    logic again;
    r          = s;
    to_burst   = 1'b0;
    to_pattern = 1'b0;
    again      = 1'b0;
    unique case (at)
      GO_TOP: begin
        if (r.flash) begin
          r.green = 1'b0;
          r = start_wait(r, MODE_FLASH, FLASH_UNITS);
        end else begin
          to_burst = 1'b1;
        end
      end
      GO_FLASH_DONE: begin
        r.green  = 1'b1;
        r.flash  = 1'b0;
        to_burst = 1'b1;
      end
      GO_ON_DONE: begin
        r.red = 1'b1;
        r = start_wait(r, MODE_BURST_OFF, BLINK_UNITS);
      end
      GO_OFF_DONE: begin
        if (r.burst <= 8'd1) begin
          r.burst = '0;
          r = start_wait(r, MODE_TAIL, BLINK_UNITS);
        end else begin
          r.burst = r.burst - 8'd1;
          r.red   = 1'b0;
          r = start_wait(r, MODE_BURST_ON, BLINK_UNITS);
        end
      end
      GO_TAIL_DONE: begin
        r.phase    = '0;
        to_pattern = 1'b1;
      end
      default: begin
      end
    endcase
    if (to_burst) begin
      if (r.burst != 8'd0) begin
        r.red = 1'b0;
        r = start_wait(r, MODE_BURST_ON, BLINK_UNITS);
      end else begin
        to_pattern = 1'b1;
      end
    end
    if (to_pattern) begin
      again = r.wake;
      r = pattern_step(r);
    end
    if (again) begin
      if (r.flash) begin
        r.green = 1'b0;
        r = start_wait(r, MODE_FLASH, FLASH_UNITS);
      end else if (r.burst != 8'd0) begin
        r.red = 1'b0;
        r = start_wait(r, MODE_BURST_ON, BLINK_UNITS);
      end else begin
        r = pattern_step(r);
      end
    end
    return r;
  endfunction

  function automatic go_t go_after(mode_t m);
    go_t g;
    unique case (m)
      MODE_FLASH:     g = GO_FLASH_DONE;
      MODE_BURST_ON:  g = GO_ON_DONE;
      MODE_BURST_OFF: g = GO_OFF_DONE;
      MODE_TAIL:      g = GO_TAIL_DONE;
      default:        g = GO_TOP;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/lsps_cfg_regs.sv
// Configuration register file: the timing unit length in tick requests.
module lsps_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lsps_pkg::apb_req_t              apb,
  output logic [lsps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [15:0]                     unit_ticks
);

  logic [15:0] unit_ticks_r;
  logic        sel_unit_ticks;
  logic        wr_en;

  assign sel_unit_ticks = (apb.paddr[lsps_pkg::CFG_ADDR_W-1:2] == lsps_pkg::REG_UNIT_TICKS);
  assign wr_en          = apb.psel && apb.penable && apb.pwrite;
  assign pready         = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= lsps_pkg::UNIT_TICKS_RESET;
    end else if (wr_en && sel_unit_ticks) begin
      unit_ticks_r <= apb.pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_unit_ticks) begin
      prdata = {{(lsps_pkg::CFG_DATA_W - 16){1'b0}}, unit_ticks_r};
    end
  end

  assign unit_ticks = unit_ticks_r;

endmodule

// File: rtl/lsps_seq_core.sv
// Sequencer state and its next-state logic for one accepted request.
module lsps_seq_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  lsps_pkg::cmd_t cmd,
  input  logic [15:0]    unit_ticks,
  output logic           red_nxt,
  output logic           green_nxt
);

  lsps_pkg::seq_t state_r;
  lsps_pkg::seq_t state_nxt;
  lsps_pkg::seq_t base;
  lsps_pkg::go_t  run_at;
  logic           run_en;
  logic           wake_en;
  logic [15:0]    prescale_inc;
  logic [31:0]    new_mask;

  always_comb begin
    base         = state_r;
    run_en       = 1'b0;
    run_at       = lsps_pkg::GO_TOP;
    wake_en      = 1'b0;
    prescale_inc = state_r.prescale + 16'd1;
    new_mask     = lsps_pkg::status_mask(cmd.status_code);
    if (fire) begin
      unique case (cmd.opcode)
        lsps_pkg::OP_TICK: begin
          if (state_r.mode != lsps_pkg::MODE_STEADY) begin
            if (prescale_inc < unit_ticks) begin
              base.prescale = prescale_inc;
            end else begin
              base.prescale = '0;
              if (state_r.units != 5'd0) begin
                base.units = state_r.units - 5'd1;
              end
              if (base.units == 5'd0) begin
                run_en = 1'b1;
                run_at = lsps_pkg::go_after(state_r.mode);
              end
            end
          end
        end
        lsps_pkg::OP_STATUS: begin
          base.burst = '0;
          if (new_mask != state_r.mask) begin
            base.mask = new_mask;
            wake_en   = 1'b1;
          end
        end
        lsps_pkg::OP_BLINK: begin
          base.burst = cmd.blink_count;
          wake_en    = 1'b1;
        end
        lsps_pkg::OP_STEADY: begin
          base.burst = '0;
          base.mask  = cmd.flag ? lsps_pkg::MASK_ON : lsps_pkg::MASK_OFF;
          wake_en    = 1'b1;
        end
        lsps_pkg::OP_ACCESS: begin
          if (cmd.flag) begin
            base.flash = 1'b1;
          end else begin
            base.burst = lsps_pkg::FAIL_BLINKS;
          end
          wake_en = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // Steady and pattern waits end at once; flash and burst waits keep a note.
    if (wake_en) begin
      if (state_r.mode == lsps_pkg::MODE_STEADY || state_r.mode == lsps_pkg::MODE_PATTERN) begin
        base.wake = 1'b0;
        run_en    = 1'b1;
        run_at    = lsps_pkg::GO_TOP;
      end else begin
        base.wake = 1'b1;
      end
    end
    state_nxt = run_en ? lsps_pkg::seq_run(base, run_at) : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mask     <= lsps_pkg::MASK_OFF;
      state_r.burst    <= '0;
      state_r.flash    <= 1'b0;
      state_r.wake     <= 1'b0;
      state_r.phase    <= '0;
      state_r.mode     <= lsps_pkg::MODE_STEADY;
      state_r.units    <= '0;
      state_r.prescale <= '0;
      state_r.red      <= 1'b1;
      state_r.green    <= 1'b1;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign red_nxt   = state_nxt.red;
  assign green_nxt = state_nxt.green;

  // Every wait other than the steady one has units left to run.
  a_units_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode != lsps_pkg::MODE_STEADY) == (state_r.units != 5'd0))
    else $error("units left does not match the wait mode");

  // A deferred wake survives only across flash and burst waits.
  a_wake_deferred: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.wake |-> (state_r.mode == lsps_pkg::MODE_FLASH ||
                      state_r.mode == lsps_pkg::MODE_BURST_ON ||
                      state_r.mode == lsps_pkg::MODE_BURST_OFF ||
                      state_r.mode == lsps_pkg::MODE_TAIL))
    else $error("wake pending outside a flash or burst wait");

  // Green is lit exactly while the flash wait runs.
  a_green_flash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.green == 1'b0) == (state_r.mode == lsps_pkg::MODE_FLASH))
    else $error("green level out of step with the flash wait");

  // A tick in the steady wait leaves the state untouched.
  a_steady_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd.opcode == lsps_pkg::OP_TICK && state_r.mode == lsps_pkg::MODE_STEADY)
    |=> $stable(state_r))
    else $error("tick changed state in the steady wait");

endmodule

// File: rtl/led_status_pattern_sequencer.sv
// Top level of the LED status pattern sequencer: handshakes, result register, config port.
//
//   Channel  Direction  Handshake                 Payload
//   in_      request    in_valid / in_ready       opcode, status_code, blink_count, flag
//   out_     result     out_valid / out_ready     red_pin, green_pin (0 lit, 1 dark)
//   cfg_     register   APB, pready tied high     unit_ticks at byte address 0
//
// Every accepted request yields one result: the two pin levels after the request.
// One request per clock while in_ready is high; its result is registered the next cycle.
// The whole step (prescaler, wait counter, resume logic) is one combinational pass
// from the sequencer state, written back at the accept edge.
// in_ready drops only while a result waits in the result register and out_ready is low.
// Reset is synchronous and active low; it sets both sequencer levels dark, not the pins.
//
// Requests are ticks and commands. A tick advances the timing unit prescaler; when
// unit_ticks ticks have gone by one unit of the current wait is spent, and when the
// wait runs out the sequencer moves on: it ends a green flash, steps through a red
// burst, or moves the status pattern to its next phase. Pattern phases alternate
// dark and lit and each lasts twice the nibble of the status mask for that phase.
// Commands set the status mask, the steady level, a blink burst or an access result;
// any command but a status that keeps the mask ends a steady or pattern wait at once; one
// given in a flash or burst is kept, so that the next steady or pattern wait ends at once.
module led_status_pattern_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_opcode,
  input  logic [2:0]                          in_status_code,
  input  logic [7:0]                          in_blink_count,
  input  logic                                in_flag,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_red_pin,
  output logic                                out_green_pin,

  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [lsps_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  lsps_pkg::cmd_t     cmd;
  lsps_pkg::apb_req_t apb;
  logic [15:0]        unit_ticks;
  logic               fire;
  logic               red_nxt;
  logic               green_nxt;
  logic               out_valid_r;
  logic               out_red_r;
  logic               out_green_r;

  assign cmd.opcode      = in_opcode;
  assign cmd.status_code = in_status_code;
  assign cmd.blink_count = in_blink_count;
  assign cmd.flag        = in_flag;

  assign apb.psel    = cfg_psel;
  assign apb.penable = cfg_penable;
  assign apb.pwrite  = cfg_pwrite;
  assign apb.paddr   = cfg_paddr;
  assign apb.pwdata  = cfg_pwdata;

  // The result register frees up in the same cycle that its result is taken,
  // so back-to-back requests flow while the consumer keeps up.
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  lsps_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .apb        (apb),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .unit_ticks (unit_ticks)
  );

  lsps_seq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .cmd        (cmd),
    .unit_ticks (unit_ticks),
    .red_nxt    (red_nxt),
    .green_nxt  (green_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Pin levels are payload and load only with a new result.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_pin   = out_red_r;
  assign out_green_pin = out_green_r;

  // Each accepted request leaves a result ready on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // The result register is never overwritten while its result is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !fire)
    else $error("request accepted while a result was stalled");

  // With nothing accepted, a taken result empties the register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !fire) |=> !out_valid_r)
    else $error("result register did not drain");

endmodule
